FILE: sv/pad_pkg.sv
`timescale 1ns / 1ps

package pad_pkg;

    localparam int DEPTH_DEF = 64;

    // operation codes
    localparam logic [2:0] OP_INS_TOP  = 3'd0;
    localparam logic [2:0] OP_INS_BOT  = 3'd1;
    localparam logic [2:0] OP_REM_TOP  = 3'd2;
    localparam logic [2:0] OP_REM_BOT  = 3'd3;
    localparam logic [2:0] OP_REM_ADDR = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    // status codes
    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STS_OVERFLOW  = 2'd2;
    localparam logic [1:0] STS_NOTFOUND  = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] page_addr;
    } req_t;

    typedef struct packed {
        logic [63:0] top_page;
        logic [63:0] bottom_page;
        logic [6:0]  entry_count;
        logic        is_empty;
        logic [1:0]  status;
    } res_t;

    // read port address select
    typedef enum logic [1:0] {
        RD_NEXT_TOP,
        RD_NEXT_BOT,
        RD_SCAN,
        RD_SHIFT
    } rd_sel_t;

    typedef struct packed {
        logic       load;
        logic       ins_top;
        logic       ins_bot;
        logic       pop_top;
        logic       pop_bot;
        logic       clear;
        logic       cap_top;
        logic       cap_bot;
        logic       scan_start;
        logic       scan_step;
        logic       shift_step;
        logic       out_load;
        rd_sel_t    rd_sel;
        logic [1:0] status;
    } pad_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       few;
        logic       top_hit;
        logic       bot_hit;
        logic       scan_hit;
        logic       scan_last;
        logic       shift_last;
    } pad_sts_t;

endpackage

FILE: sv/pad_datapath.sv
`timescale 1ns / 1ps

module pad_datapath #(
    parameter int DEPTH = pad_pkg::DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pad_pkg::req_t     s_req,
    input  pad_pkg::pad_cmd_t cmd,
    output pad_pkg::pad_sts_t sts,
    output pad_pkg::res_t     res
);
    import pad_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // circular buffer: logical position 0 is the top, at physical head_reg
    logic [63:0] mem [DEPTH];

    logic [2:0]       op_reg;
    logic [63:0]      addr_reg;
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      top_reg;
    logic [63:0]      bot_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [63:0]      rd_data_reg;
    res_t             res_reg;

    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] head_inc;
    logic [CNT_W-1:0] cnt_m2;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [63:0]      wr_data;

    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] h,
                                              input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(h) + (CNT_W + 1)'(pos);
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - 1'b1;
    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign cnt_m2   = (cnt_reg >= CNT_W'(2)) ? cnt_reg - CNT_W'(2) : '0;

    always_comb begin
        case (cmd.rd_sel)
            RD_NEXT_TOP: rd_addr = phys(head_reg, CNT_W'(1));
            RD_NEXT_BOT: rd_addr = phys(head_reg, cnt_m2);
            RD_SCAN:     rd_addr = phys(head_reg, idx_reg + CNT_W'(1));
            RD_SHIFT:    rd_addr = phys(head_reg, idx_reg + CNT_W'(2));
            default:     rd_addr = phys(head_reg, CNT_W'(1));
        endcase
    end

    always_comb begin
        wr_en   = cmd.ins_top | cmd.ins_bot | cmd.shift_step;
        wr_addr = phys(head_reg, idx_reg);
        wr_data = rd_data_reg;
        if (cmd.ins_top) begin
            wr_addr = head_dec;
            wr_data = addr_reg;
        end else if (cmd.ins_bot) begin
            wr_addr = phys(head_reg, cnt_reg);
            wr_data = addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.clear) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end else if (cmd.ins_top) begin
            head_reg <= head_dec;
            cnt_reg  <= cnt_reg + 1'b1;
        end else if (cmd.ins_bot) begin
            cnt_reg <= cnt_reg + 1'b1;
        end else if (cmd.pop_top) begin
            head_reg <= head_inc;
            cnt_reg  <= cnt_reg - 1'b1;
        end else if (cmd.pop_bot) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_req.op;
            addr_reg <= s_req.page_addr;
        end
        if (cmd.ins_top) begin
            top_reg <= addr_reg;
            if (cnt_reg == '0) begin
                bot_reg <= addr_reg;
            end
        end else if (cmd.ins_bot) begin
            bot_reg <= addr_reg;
            if (cnt_reg == '0) begin
                top_reg <= addr_reg;
            end
        end
        if (cmd.cap_top) begin
            top_reg <= rd_data_reg;
        end
        if (cmd.cap_bot) begin
            bot_reg <= rd_data_reg;
        end
        if (cmd.scan_start) begin
            idx_reg <= CNT_W'(1);
        end else if (cmd.scan_step || cmd.shift_step) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.out_load) begin
            res_reg.top_page    <= (cnt_reg == '0) ? '1 : top_reg;
            res_reg.bottom_page <= (cnt_reg == '0) ? '1 : bot_reg;
            res_reg.entry_count <= 7'(cnt_reg);
            res_reg.is_empty    <= (cnt_reg == '0);
            res_reg.status      <= cmd.status;
        end
    end

    assign sts.op         = op_reg;
    assign sts.empty      = (cnt_reg == '0);
    assign sts.full       = (cnt_reg == DEPTH_C);
    assign sts.few        = (cnt_reg < CNT_W'(3));
    assign sts.top_hit    = (top_reg == addr_reg);
    assign sts.bot_hit    = (bot_reg == addr_reg);
    assign sts.scan_hit   = (rd_data_reg == addr_reg);
    assign sts.scan_last  = (idx_reg == cnt_m2);
    assign sts.shift_last = (idx_reg == cnt_m2);

    assign res = res_reg;

endmodule

FILE: sv/pad_ctrl.sv
`timescale 1ns / 1ps

module pad_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pad_pkg::pad_sts_t sts,
    output pad_pkg::pad_cmd_t cmd
);
    import pad_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CAP_TOP,
        ST_CAP_BOT,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic [1:0] status_reg, status_next;

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        cmd.rd_sel   = RD_NEXT_TOP;
        cmd.status   = status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    status_next = STS_DONE;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (sts.op)
                    OP_INS_TOP: begin
                        if (sts.full) status_next = STS_OVERFLOW;
                        else cmd.ins_top = 1'b1;
                    end
                    OP_INS_BOT: begin
                        if (sts.full) status_next = STS_OVERFLOW;
                        else cmd.ins_bot = 1'b1;
                    end
                    OP_REM_TOP: begin
                        if (sts.empty) begin
                            status_next = STS_UNDERFLOW;
                        end else begin
                            cmd.pop_top = 1'b1;
                            cmd.rd_sel  = RD_NEXT_TOP;
                            state_next  = ST_CAP_TOP;
                        end
                    end
                    OP_REM_BOT: begin
                        if (sts.empty) begin
                            status_next = STS_UNDERFLOW;
                        end else begin
                            cmd.pop_bot = 1'b1;
                            cmd.rd_sel  = RD_NEXT_BOT;
                            state_next  = ST_CAP_BOT;
                        end
                    end
                    OP_REM_ADDR: begin
                        if (sts.empty) begin
                            status_next = STS_UNDERFLOW;
                        end else if (sts.top_hit) begin
                            cmd.pop_top = 1'b1;
                            cmd.rd_sel  = RD_NEXT_TOP;
                            state_next  = ST_CAP_TOP;
                        end else if (sts.bot_hit) begin
                            cmd.pop_bot = 1'b1;
                            cmd.rd_sel  = RD_NEXT_BOT;
                            state_next  = ST_CAP_BOT;
                        end else if (sts.few) begin
                            // no middle entries to walk
                            status_next = STS_NOTFOUND;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.rd_sel     = RD_NEXT_TOP;
                            state_next     = ST_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_CAP_TOP: begin
                cmd.cap_top = 1'b1;
                state_next  = ST_DONE;
            end
            ST_CAP_BOT: begin
                cmd.cap_bot = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN: begin
                // read of the next position is in flight every cycle
                cmd.rd_sel = RD_SCAN;
                if (sts.scan_hit) begin
                    state_next = ST_SHIFT;
                end else if (sts.scan_last) begin
                    status_next = STS_NOTFOUND;
                    state_next  = ST_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                // move entry idx+1 into idx, fetch idx+2
                cmd.rd_sel     = RD_SHIFT;
                cmd.shift_step = 1'b1;
                if (sts.shift_last) begin
                    cmd.pop_bot = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            status_reg  <= STS_DONE;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: sv/page_access_deque_top.sv
`timescale 1ns / 1ps

// Page access deque: an ordered store of up to DEPTH 64-bit page addresses
// with a top and a bottom end, held in a circular buffer in one memory.
// Each request carries one operation (insert top/bottom, remove top/bottom,
// remove by address, clear) and returns one result with the new top and
// bottom (all ones when empty), the count, an empty flag and a status.
// One request is processed at a time. Inserts, clear, no-ops and error cases
// go from the execute state straight to the done state, which loads the
// result register; the next request can be taken in the cycle after that.
// Remove top/bottom passes a capture state as well, since the new end entry
// is fetched through the registered memory read port. Remove by address
// checks top then bottom, then walks the middle entries one per cycle. On a
// hit it closes the gap from the hit position on, moving each later entry up
// one place, one write per cycle on the single write port. A new request is
// taken while the previous result waits at m_. A finished result waits for
// the previous one to be taken.
module page_access_deque_top #(
    parameter int DEPTH = pad_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pad_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output pad_pkg::res_t m_res
);
    import pad_pkg::*;

    pad_cmd_t cmd;
    pad_sts_t sts;

    pad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pad_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .cmd     (cmd),
        .sts     (sts),
        .res     (m_res)
    );

endmodule

FILE: sim/page_deque_checker.sv
`timescale 1ns / 1ps

module page_deque_checker #(
    parameter int DEPTH = pad_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  pad_pkg::req_t s_req,
    input  logic          m_valid,
    input  logic          m_ready,
    input  pad_pkg::res_t m_res,
    output int            pending,
    output int            fail_count
);
    import pad_pkg::*;

    // position 0 is the top, the last position is the bottom
    logic [63:0] page_stack[$];
    res_t        expected_res[$];
    res_t        want;
    int          mismatch_cnt = 0;

    assign fail_count = mismatch_cnt;

    function automatic res_t apply_page_op(input req_t rq);
        res_t r;
        int   hit;
        r = '0;
        r.status = STS_DONE;
        hit = -1;
        case (rq.op)
            OP_INS_TOP: begin
                if (page_stack.size() >= DEPTH) r.status = STS_OVERFLOW;
                else page_stack.push_front(rq.page_addr);
            end
            OP_INS_BOT: begin
                if (page_stack.size() >= DEPTH) r.status = STS_OVERFLOW;
                else page_stack.push_back(rq.page_addr);
            end
            OP_REM_TOP: begin
                if (page_stack.size() == 0) r.status = STS_UNDERFLOW;
                else void'(page_stack.pop_front());
            end
            OP_REM_BOT: begin
                if (page_stack.size() == 0) r.status = STS_UNDERFLOW;
                else void'(page_stack.pop_back());
            end
            OP_REM_ADDR: begin
                if (page_stack.size() == 0) begin
                    r.status = STS_UNDERFLOW;
                end else begin
                    // top first, then bottom, then walk from the top
                    if (page_stack[0] == rq.page_addr) begin
                        hit = 0;
                    end else if (page_stack[page_stack.size() - 1] == rq.page_addr) begin
                        hit = page_stack.size() - 1;
                    end else begin
                        for (int i = 1; i < page_stack.size(); i++) begin
                            if (hit < 0 && page_stack[i] == rq.page_addr) hit = i;
                        end
                    end
                    if (hit < 0) r.status = STS_NOTFOUND;
                    else page_stack.delete(hit);
                end
            end
            OP_CLEAR: page_stack.delete();
            default: ;
        endcase
        if (page_stack.size() == 0) begin
            r.top_page    = '1;
            r.bottom_page = '1;
        end else begin
            r.top_page    = page_stack[0];
            r.bottom_page = page_stack[page_stack.size() - 1];
        end
        r.entry_count = 7'(page_stack.size());
        r.is_empty    = (page_stack.size() == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s mismatch: expected %h, got %h", name, exp_val, got_val);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_res.delete();
            page_stack.delete();
        end else begin
            // result first: it always belongs to an earlier request
            if (m_valid && m_ready) begin
                if (expected_res.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = expected_res.pop_front();
                    check_field("top_page", want.top_page, m_res.top_page);
                    check_field("bottom_page", want.bottom_page, m_res.bottom_page);
                    check_field("entry_count", 64'(want.entry_count), 64'(m_res.entry_count));
                    check_field("is_empty", 64'(want.is_empty), 64'(m_res.is_empty));
                    check_field("status", 64'(want.status), 64'(m_res.status));
                end
            end
            if (s_valid && s_ready) expected_res.push_back(apply_page_op(s_req));
        end
        pending <= expected_res.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pad_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int RAND_ITEMS = 1125;
    localparam int POOL_SIZE  = 24;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 600;
    localparam int PAUSE_AT   = 550;

    // op codes the block treats as no-ops
    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_t        s_req;
    logic        m_valid;
    logic        m_ready;
    res_t        m_res;
    int          pending;
    int          fail_count;

    logic        steady = 1'b0;
    int          sent_count = 0;
    logic [63:0] page_pool[POOL_SIZE];

    page_access_deque_top #(.DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    page_deque_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off so the block backs up
    initial begin
        int  hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 8);
            end
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [63:0] addr);
        if (!steady) begin
            while ($urandom_range(99) < 8) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_req   <= '{op: op, page_addr: addr};
        do @(posedge aclk); while (!s_ready);
        sent_count <= sent_count + 1;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_page();
        if ($urandom_range(99) < 85) return page_pool[$urandom_range(POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [2:0] pick_op(input mix_t mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 40) return OP_INS_TOP;
                if (r < 80) return OP_INS_BOT;
                if (r < 87) return OP_REM_TOP;
                if (r < 93) return OP_REM_BOT;
                return OP_REM_ADDR;
            end
            MIX_DRAIN: begin
                if (r < 10) return OP_INS_TOP;
                if (r < 20) return OP_INS_BOT;
                if (r < 40) return OP_REM_TOP;
                if (r < 60) return OP_REM_BOT;
                if (r < 97) return OP_REM_ADDR;
                if (r < 98) return OP_CLEAR;
                if (r < 99) return OP_RSVD_A;
                return OP_RSVD_B;
            end
            default: begin
                if (r < 25) return OP_INS_TOP;
                if (r < 50) return OP_INS_BOT;
                if (r < 62) return OP_REM_TOP;
                if (r < 74) return OP_REM_BOT;
                if (r < 96) return OP_REM_ADDR;
                if (r < 98) return OP_CLEAR;
                if (r < 99) return OP_RSVD_A;
                return OP_RSVD_B;
            end
        endcase
    endfunction

    initial begin
        logic [63:0] pg_x;
        logic [63:0] pg_y;
        logic [63:0] pg_c;
        mix_t        mix;
        int          phase_left;

        pg_x = 64'h0000_1000_0000_0000;
        pg_y = 64'h7fff_ffff_ffff_f000;
        pg_c = 64'h8000_0000_0000_1000;
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = {$urandom, $urandom};

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req   = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // errors and no-ops on an empty store
        send_request(OP_REM_TOP, 64'h0);
        send_request(OP_REM_BOT, 64'h0);
        send_request(OP_REM_ADDR, 64'h0);
        send_request(OP_CLEAR, 64'h0);
        send_request(OP_RSVD_A, '1);
        send_request(OP_RSVD_B, '1);
        // extreme addresses, then remove miss / top / bottom
        send_request(OP_INS_TOP, 64'h0);
        send_request(OP_INS_BOT, '1);
        send_request(OP_INS_TOP, 64'h5555_5555_5555_5555);
        send_request(OP_INS_BOT, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(OP_REM_ADDR, 64'h1234);
        send_request(OP_REM_ADDR, 64'h5555_5555_5555_5555);
        send_request(OP_REM_ADDR, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(OP_CLEAR, 64'h0);
        // top and bottom both match: top goes
        send_request(OP_INS_TOP, pg_x);
        send_request(OP_INS_BOT, pg_y);
        send_request(OP_INS_BOT, pg_x);
        send_request(OP_REM_ADDR, pg_x);
        // bottom and a middle entry match: bottom goes
        send_request(OP_INS_TOP, pg_c);
        send_request(OP_INS_BOT, pg_y);
        send_request(OP_REM_ADDR, pg_y);
        // match found only by the walk
        send_request(OP_REM_ADDR, pg_y);
        send_request(OP_REM_TOP, 64'h0);
        send_request(OP_REM_BOT, 64'h0);

        mix = MIX_FILL;
        phase_left = 150;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (phase_left == 0) begin
                mix = mix_t'($urandom_range(2));
                phase_left = $urandom_range(40, 200);
            end
            phase_left--;
            if (n == 700) steady <= 1'b1;
            if (n == 900) steady <= 1'b0;
            if (n == PAUSE_AT) wait_drained();
            send_request(pick_op(mix), pick_page());
        end

        wait_drained();
        repeat (2 * DEPTH + 20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: page_access_deque_top.f
sv/pad_pkg.sv
sv/pad_datapath.sv
sv/pad_ctrl.sv
sv/page_access_deque_top.sv
sim/page_deque_checker.sv
sim/testbench.sv
